// ===== rtl/core/btpc_pkg.sv =====
`timescale 1ns / 1ps
package btpc_pkg;

  localparam int unsigned RawW   = 20;
  localparam int unsigned TempW  = 32;
  localparam int unsigned PressW = 64;
  localparam int unsigned CalW   = 16;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_T1_T2 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_T3_P1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_P2_P3 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_P4_P5 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_P6_P7 = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_P8_P9 = 3'd5;

  localparam logic [PressW-1:0] FineOffset = 64'd128000;
  localparam logic [PressW-1:0] PressBase  = 64'd1048576;
  localparam logic [PressW-1:0] PressScale = 64'd3125;
  localparam logic [PressW-1:0] OneQ47     = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic [CalW-1:0] t1;
    logic [CalW-1:0] t2;
    logic [CalW-1:0] t3;
  } tcal_t;

  function automatic logic [PressW-1:0] sext16(input logic [CalW-1:0] v);
    return {{(PressW-CalW){v[CalW-1]}}, v};
  endfunction

endpackage

// ===== rtl/core/btpc_pipe.sv =====
`timescale 1ns / 1ps
module btpc_pipe #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  logic [W-1:0] data_i,
  output logic         vld_o,
  output logic [W-1:0] data_o
);

  logic         vld_q  [DEPTH];
  logic [W-1:0] data_q [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    logic         vld_d;
    logic [W-1:0] data_d;
    if (k == 0) begin : g_first
      assign vld_d  = vld_i;
      assign data_d = data_i;
    end else begin : g_next
      assign vld_d  = vld_q[k-1];
      assign data_d = data_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_d;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        data_q[k] <= data_d;
      end
    end
  end

  assign vld_o  = vld_q[DEPTH-1];
  assign data_o = data_q[DEPTH-1];

endmodule

// ===== rtl/core/btpc_mul64.sv =====
`timescale 1ns / 1ps
module btpc_mul64 (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [btpc_pkg::PressW-1:0] a_i,
  input  logic [btpc_pkg::PressW-1:0] b_i,
  output logic [btpc_pkg::PressW-1:0] p_o
);

  localparam int unsigned HalfW = btpc_pkg::PressW / 2;

  logic [btpc_pkg::PressW-1:0] ll_d, ll_q;
  logic [HalfW-1:0]            lh_d, lh_q, hl_d, hl_q;
  logic [btpc_pkg::PressW-1:0] p_d, p_q;

  // low 64 bits of the product from three 32x32 partial products
  assign ll_d = a_i[HalfW-1:0] * b_i[HalfW-1:0];
  assign lh_d = a_i[HalfW-1:0] * b_i[btpc_pkg::PressW-1:HalfW];
  assign hl_d = a_i[btpc_pkg::PressW-1:HalfW] * b_i[HalfW-1:0];
  assign p_d  = ll_q + {lh_q + hl_q, {HalfW{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      p_q  <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/btpc_div64.sv =====
`timescale 1ns / 1ps
module btpc_div64 #(
  parameter int unsigned SW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [btpc_pkg::PressW-1:0] num_i,
  input  logic [btpc_pkg::PressW-1:0] den_i,
  input  logic [SW-1:0]               side_i,
  output logic                        vld_o,
  output logic [btpc_pkg::PressW-1:0] quo_o,
  output logic [SW-1:0]               side_o
);

  localparam int unsigned N = btpc_pkg::PressW;

  logic         vld_q  [N+2];
  logic [N-1:0] rem_q  [N+1];
  logic [N-1:0] nq_q   [N+1];
  logic [N-1:0] dm_q   [N+1];
  logic         neg_q  [N+1];
  logic [SW-1:0] side_q [N+2];
  logic [N-1:0] quo_q;

  // magnitudes and sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      nq_q[0]   <= num_i[N-1] ? (~num_i + 1'b1) : num_i;
      dm_q[0]   <= den_i[N-1] ? (~den_i + 1'b1) : den_i;
      neg_q[0]  <= num_i[N-1] ^ den_i[N-1];
      side_q[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  // one restoring step per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [N:0] trial;
    logic [N:0] diff;
    logic       ge;
    assign trial = {rem_q[k], nq_q[k][N-1]};
    assign diff  = trial - {1'b0, dm_q[k]};
    assign ge    = trial >= {1'b0, dm_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? diff[N-1:0] : trial[N-1:0];
        nq_q[k+1]   <= {nq_q[k][N-2:0], ge};
        dm_q[k+1]   <= dm_q[k];
        neg_q[k+1]  <= neg_q[k];
        side_q[k+1] <= side_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  // sign restore
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q       <= neg_q[N] ? (~nq_q[N] + 1'b1) : nq_q[N];
      side_q[N+1] <= side_q[N];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[N+1] <= 1'b0;
    end else if (en_i) begin
      vld_q[N+1] <= vld_q[N];
    end
  end

  assign vld_o  = vld_q[N+1];
  assign quo_o  = quo_q;
  assign side_o = side_q[N+1];

endmodule

// ===== rtl/core/btpc_temp.sv =====
`timescale 1ns / 1ps
module btpc_temp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [btpc_pkg::RawW-1:0]   adc_t_i,
  input  logic [btpc_pkg::RawW-1:0]   adc_p_i,
  input  btpc_pkg::tcal_t             cal_i,
  output logic                        vld_o,
  output logic [btpc_pkg::TempW-1:0]  temp_o,
  output logic [btpc_pkg::PressW-1:0] v1_o,
  output logic [btpc_pkg::RawW-1:0]   adc_p_o
);

  localparam int unsigned TW = btpc_pkg::TempW;
  localparam int unsigned RW = btpc_pkg::RawW;

  logic [4:0]    vld_q;
  logic [RW-1:0] adcp1_q, adcp2_q, adcp3_q, adcp4_q, adcp5_q;
  logic [TW-1:0] a_q, b_q, m1_q, m2_q, tv1_q, m3_q, tfine_q, temp_q;
  logic [TW-1:0] a_d, b_d, t2x, t3x, sq12, tv2, tf5;
  logic [btpc_pkg::PressW-1:0] v1_q;

  assign a_d  = {15'd0, adc_t_i[RW-1:3]} - {15'd0, cal_i.t1, 1'b0};
  assign b_d  = {16'd0, adc_t_i[RW-1:4]} - {16'd0, cal_i.t1};
  assign t2x  = {{16{cal_i.t2[15]}}, cal_i.t2};
  assign t3x  = {{16{cal_i.t3[15]}}, cal_i.t3};
  assign sq12 = $signed(m2_q) >>> 12;
  assign tv2  = $signed(m3_q) >>> 14;
  assign tf5  = (tfine_q << 2) + tfine_q + 32'd128;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q     <= a_d;
      b_q     <= b_d;
      adcp1_q <= adc_p_i;
      m1_q    <= a_q * t2x;
      m2_q    <= b_q * b_q;
      adcp2_q <= adcp1_q;
      tv1_q   <= $signed(m1_q) >>> 11;
      m3_q    <= sq12 * t3x;
      adcp3_q <= adcp2_q;
      tfine_q <= tv1_q + tv2;
      adcp4_q <= adcp3_q;
      temp_q  <= $signed(tf5) >>> 8;
      v1_q    <= {{32{tfine_q[TW-1]}}, tfine_q} - btpc_pkg::FineOffset;
      adcp5_q <= adcp4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  assign vld_o   = vld_q[4];
  assign temp_o  = temp_q;
  assign v1_o    = v1_q;
  assign adc_p_o = adcp5_q;

endmodule

// ===== rtl/core/baro_temp_pressure_compensation_core.sv =====
`timescale 1ns / 1ps
// Integer temperature and pressure compensation for a barometric sensor. Each transaction
// carries one raw temperature and one raw pressure sample; the result carries temperature in
// 0.01 degC, pressure in Pa as Q24.8 and a flag that is low (pressure 0) when the calibration
// divisor is zero. One transaction is taken every cycle while the output is not stalled;
// the whole pipeline, including the 64-stage radix-2 divider, holds while the output is
// stalled. The user must write calibration words through the cfg port only while no
// transaction is in flight; the block itself does not enforce this.
module baro_temp_pressure_compensation_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [btpc_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [btpc_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [39:0]                   s_axis_tdata,  // raw_temperature, raw_pressure
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,  // temperature_centi, pressure_q24_8
  output logic [0:0]                    m_axis_tuser   // pressure_valid
);

  localparam int unsigned PW = btpc_pkg::PressW;
  localparam int unsigned TW = btpc_pkg::TempW;
  localparam int unsigned RW = btpc_pkg::RawW;

  logic [btpc_pkg::CfgW-1:0] cal_t1t2_q, cal_t3p1_q, cal_p2p3_q;
  logic [btpc_pkg::CfgW-1:0] cal_p4p5_q, cal_p6p7_q, cal_p8p9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t1t2_q <= '0;
      cal_t3p1_q <= '0;
      cal_p2p3_q <= '0;
      cal_p4p5_q <= '0;
      cal_p6p7_q <= '0;
      cal_p8p9_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        btpc_pkg::CFG_T1_T2: cal_t1t2_q <= cfg_wdata_i;
        btpc_pkg::CFG_T3_P1: cal_t3p1_q <= cfg_wdata_i;
        btpc_pkg::CFG_P2_P3: cal_p2p3_q <= cfg_wdata_i;
        btpc_pkg::CFG_P4_P5: cal_p4p5_q <= cfg_wdata_i;
        btpc_pkg::CFG_P6_P7: cal_p6p7_q <= cfg_wdata_i;
        btpc_pkg::CFG_P8_P9: cal_p8p9_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  btpc_pkg::tcal_t tcal;
  logic [PW-1:0]   p1x, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;

  assign tcal.t1 = cal_t1t2_q[15:0];
  assign tcal.t2 = cal_t1t2_q[31:16];
  assign tcal.t3 = cal_t3p1_q[15:0];
  assign p1x = {48'd0, cal_t3p1_q[31:16]};
  assign p2x = btpc_pkg::sext16(cal_p2p3_q[15:0]);
  assign p3x = btpc_pkg::sext16(cal_p2p3_q[31:16]);
  assign p4x = btpc_pkg::sext16(cal_p4p5_q[15:0]);
  assign p5x = btpc_pkg::sext16(cal_p4p5_q[31:16]);
  assign p6x = btpc_pkg::sext16(cal_p6p7_q[15:0]);
  assign p7x = btpc_pkg::sext16(cal_p6p7_q[31:16]);
  assign p8x = btpc_pkg::sext16(cal_p8p9_q[15:0]);
  assign p9x = btpc_pkg::sext16(cal_p8p9_q[31:16]);

  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // temperature
  logic          t_vld;
  logic [TW-1:0] t_temp;
  logic [PW-1:0] t_v1;
  logic [RW-1:0] t_adcp;

  btpc_temp u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (s_axis_tvalid),
    .adc_t_i (s_axis_tdata[19:0]),
    .adc_p_i (s_axis_tdata[39:20]),
    .cal_i   (tcal),
    .vld_o   (t_vld),
    .temp_o  (t_temp),
    .v1_o    (t_v1),
    .adc_p_o (t_adcp)
  );

  // v1 squared, v1*p5, v1*p2
  logic [PW-1:0] sq, x5, x2;
  logic          a_vld;
  logic [TW+RW-1:0] a_side;

  btpc_mul64 u_mul_sq (.clk_i(clk_i), .en_i(en), .a_i(t_v1), .b_i(t_v1), .p_o(sq));
  btpc_mul64 u_mul_x5 (.clk_i(clk_i), .en_i(en), .a_i(t_v1), .b_i(p5x),  .p_o(x5));
  btpc_mul64 u_mul_x2 (.clk_i(clk_i), .en_i(en), .a_i(t_v1), .b_i(p2x),  .p_o(x2));

  btpc_pipe #(.W(TW+RW), .DEPTH(2)) u_pipe_a (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(t_vld),
    .data_i({t_temp, t_adcp}), .vld_o(a_vld), .data_o(a_side)
  );

  // sq*p6, sq*p3
  logic [PW-1:0] v2a, v1a;
  logic          b_vld;
  logic [TW+RW+2*PW-1:0] b_side;

  btpc_mul64 u_mul_p6 (.clk_i(clk_i), .en_i(en), .a_i(sq), .b_i(p6x), .p_o(v2a));
  btpc_mul64 u_mul_p3 (.clk_i(clk_i), .en_i(en), .a_i(sq), .b_i(p3x), .p_o(v1a));

  btpc_pipe #(.W(TW+RW+2*PW), .DEPTH(2)) u_pipe_b (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(a_vld),
    .data_i({a_side, x5, x2}), .vld_o(b_vld), .data_o(b_side)
  );

  // sum the polynomial terms
  logic [PW-1:0] b_x5, b_x2, v1a_sh;
  logic [PW-1:0] c_v2_q, c_v1b_q;
  logic [TW+RW-1:0] c_side_q;
  logic          c_vld_q;

  assign b_x5   = b_side[2*PW-1:PW];
  assign b_x2   = b_side[PW-1:0];
  assign v1a_sh = $signed(v1a) >>> 8;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_v2_q   <= v2a + (b_x5 << 17) + (p4x << 35);
      c_v1b_q  <= v1a_sh + (b_x2 << 12) + btpc_pkg::OneQ47;
      c_side_q <= b_side[TW+RW+2*PW-1:2*PW];
    end
  end

  // times p1
  logic [PW-1:0] v1c;
  logic          d_vld;
  logic [TW+RW+PW-1:0] d_side;

  btpc_mul64 u_mul_p1 (.clk_i(clk_i), .en_i(en), .a_i(c_v1b_q), .b_i(p1x), .p_o(v1c));

  btpc_pipe #(.W(TW+RW+PW), .DEPTH(2)) u_pipe_d (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(c_vld_q),
    .data_i({c_side_q, c_v2_q}), .vld_o(d_vld), .data_o(d_side)
  );

  // divisor and numerator
  logic [PW-1:0] d_pp, d_v2;
  logic [RW-1:0] d_adcp;
  logic [PW-1:0] e_den_q, e_nn_q;
  logic [TW-1:0] e_temp_q;
  logic          e_pv_q, e_vld_q;

  assign d_adcp = d_side[PW+RW-1:PW];
  assign d_v2   = d_side[PW-1:0];
  assign d_pp   = btpc_pkg::PressBase - {44'd0, d_adcp};

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_den_q  <= $signed(v1c) >>> 33;
      e_pv_q   <= |v1c[PW-1:33];
      e_nn_q   <= (d_pp << 31) - d_v2;
      e_temp_q <= d_side[TW+RW+PW-1:RW+PW];
    end
  end

  // times 3125
  logic [PW-1:0] f_num;
  logic          f_vld;
  logic [TW+1+PW-1:0] f_side;

  btpc_mul64 u_mul_sc (
    .clk_i(clk_i), .en_i(en), .a_i(e_nn_q), .b_i(btpc_pkg::PressScale), .p_o(f_num)
  );

  btpc_pipe #(.W(TW+1+PW), .DEPTH(2)) u_pipe_f (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(e_vld_q),
    .data_i({e_temp_q, e_pv_q, e_den_q}), .vld_o(f_vld), .data_o(f_side)
  );

  // divide
  logic [PW-1:0] q;
  logic          q_vld;
  logic [TW:0]   q_side;

  btpc_div64 #(.SW(TW+1)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f_vld),
    .num_i  (f_num),
    .den_i  (f_side[PW-1:0]),
    .side_i (f_side[TW+PW:PW]),
    .vld_o  (q_vld),
    .quo_o  (q),
    .side_o (q_side)
  );

  // q13 squared, p8*q
  logic [PW-1:0] q13, q13sq, w2m;
  logic          g_vld;
  logic [TW+1+PW-1:0] g_side;

  assign q13 = $signed(q) >>> 13;

  btpc_mul64 u_mul_qq (.clk_i(clk_i), .en_i(en), .a_i(q13), .b_i(q13), .p_o(q13sq));
  btpc_mul64 u_mul_p8 (.clk_i(clk_i), .en_i(en), .a_i(p8x), .b_i(q),   .p_o(w2m));

  btpc_pipe #(.W(TW+1+PW), .DEPTH(2)) u_pipe_g (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(q_vld),
    .data_i({q_side, q}), .vld_o(g_vld), .data_o(g_side)
  );

  // times p9
  logic [PW-1:0] w1m;
  logic          h_vld;
  logic [TW+1+2*PW-1:0] h_side;

  btpc_mul64 u_mul_p9 (.clk_i(clk_i), .en_i(en), .a_i(q13sq), .b_i(p9x), .p_o(w1m));

  btpc_pipe #(.W(TW+1+2*PW), .DEPTH(2)) u_pipe_h (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(g_vld),
    .data_i({g_side, w2m}), .vld_o(h_vld), .data_o(h_side)
  );

  // final sum and offset
  logic [PW-1:0] h_q, h_w2, w1_sh, w2_sh, i_sum_sh, i_press;
  logic [PW-1:0] i_sum_q;
  logic [TW-1:0] i_temp_q, out_temp_q, out_press_q;
  logic          i_pv_q, i_vld_q, out_pv_q;

  assign h_w2     = h_side[PW-1:0];
  assign h_q      = h_side[2*PW-1:PW];
  assign w1_sh    = $signed(w1m) >>> 25;
  assign w2_sh    = $signed(h_w2) >>> 19;
  assign i_sum_sh = $signed(i_sum_q) >>> 8;
  assign i_press  = i_sum_sh + (p7x << 4);

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_sum_q     <= h_q + w1_sh + w2_sh;
      i_pv_q      <= h_side[2*PW];
      i_temp_q    <= h_side[TW+2*PW:2*PW+1];
      out_temp_q  <= i_temp_q;
      out_press_q <= i_pv_q ? i_press[TW-1:0] : '0;
      out_pv_q    <= i_pv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q   <= 1'b0;
      e_vld_q   <= 1'b0;
      i_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q   <= b_vld;
      e_vld_q   <= d_vld;
      i_vld_q   <= h_vld;
      out_vld_q <= i_vld_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_press_q, out_temp_q};
  assign m_axis_tuser  = out_pv_q;

endmodule

// ===== rtl/core/btpc_checker.sv =====
`timescale 1ns / 1ps
module btpc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [63:0]                  m_axis_tdata,
  input logic [0:0]                   m_axis_tuser
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // input side follows output back-pressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // invalid pressure reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[63:32] == 32'd0)
    else $error("pressure not zero on zero divisor");

  // no result right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid out of reset");

endmodule

bind baro_temp_pressure_compensation_core btpc_checker u_btpc_checker (.*);

// ===== sim/baro_temp_pressure_compensation_core_tb.sv =====
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_core_tb;

  localparam logic [btpc_pkg::CfgIdxW-1:0] CfgUnused = 3'd6;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned NumPhases = 12;
  localparam int unsigned ItemsPerPhase = 104;

  typedef struct packed {
    logic [btpc_pkg::RawW-1:0] adc_press;
    logic [btpc_pkg::RawW-1:0] adc_temp;
  } sample_t;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] press_q24_8;
    logic        press_valid;
  } comp_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [btpc_pkg::CfgIdxW-1:0]   cfg_addr_i = btpc_pkg::CFG_T1_T2;
  logic [btpc_pkg::CfgW-1:0]      cfg_wdata_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [39:0]                    s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [63:0]                    m_axis_tdata;
  logic [0:0]                     m_axis_tuser;

  logic [btpc_pkg::CfgW-1:0] calib [6];
  sample_t         sample_q[$];
  comp_t           comp_q[$];
  int unsigned     err_cnt = 0;
  int unsigned     idle_cnt = 0;
  int unsigned     src_gap = 0;
  int unsigned     sink_stall = 0;
  bit              burst = 1'b0;

  baro_temp_pressure_compensation_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] asr32(input logic [31:0] x, input int s);
    logic signed [31:0] y;
    y = x;
    return y >>> s;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int s);
    logic signed [63:0] y;
    y = x;
    return y >>> s;
  endfunction

  function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] nm, dm, q;
    nm = n[63] ? -n : n;
    dm = d[63] ? -d : d;
    q = nm / dm;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic comp_t compensate(input sample_t s);
    logic [31:0] t1, t2, t3, a, b, tv1, tv2, tfine;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, pp, n, q, q13, w1, w2;
    comp_t r;
    t1 = {16'b0, calib[btpc_pkg::CFG_T1_T2][15:0]};
    t2 = {{16{calib[btpc_pkg::CFG_T1_T2][31]}}, calib[btpc_pkg::CFG_T1_T2][31:16]};
    t3 = {{16{calib[btpc_pkg::CFG_T3_P1][15]}}, calib[btpc_pkg::CFG_T3_P1][15:0]};
    p1 = {48'b0, calib[btpc_pkg::CFG_T3_P1][31:16]};
    p2 = sx16(calib[btpc_pkg::CFG_P2_P3][15:0]);
    p3 = sx16(calib[btpc_pkg::CFG_P2_P3][31:16]);
    p4 = sx16(calib[btpc_pkg::CFG_P4_P5][15:0]);
    p5 = sx16(calib[btpc_pkg::CFG_P4_P5][31:16]);
    p6 = sx16(calib[btpc_pkg::CFG_P6_P7][15:0]);
    p7 = sx16(calib[btpc_pkg::CFG_P6_P7][31:16]);
    p8 = sx16(calib[btpc_pkg::CFG_P8_P9][15:0]);
    p9 = sx16(calib[btpc_pkg::CFG_P8_P9][31:16]);

    a = ({12'b0, s.adc_temp} >> 3) - (t1 << 1);
    tv1 = asr32(a * t2, 11);
    b = ({12'b0, s.adc_temp} >> 4) - t1;
    tv2 = asr32(asr32(b * b, 12) * t3, 14);
    tfine = tv1 + tv2;
    r.temp_centi = asr32(tfine * 32'd5 + 32'd128, 8);

    v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64((64'h0000_8000_0000_0000 + v1) * p1, 33);
    r.press_q24_8 = '0;
    r.press_valid = 1'b0;
    if (v1 != 64'd0) begin
      pp = 64'd1048576 - {44'b0, s.adc_press};
      n = ((pp << 31) - v2) * 64'd3125;
      q = div_trunc(n, v1);
      q13 = asr64(q, 13);
      w1 = asr64(p9 * q13 * q13, 25);
      w2 = asr64(p8 * q, 19);
      q = asr64(q + w1 + w2, 8) + (p7 << 4);
      r.press_q24_8 = q[31:0];
      r.press_valid = 1'b1;
    end
    return r;
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        comp_q.push_back(compensate(sample_t'(s_axis_tdata)));
        if ($urandom_range(0, 149) == 0) burst <= !burst;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          s_axis_tdata <= {sample_q[0].adc_press, sample_q[0].adc_temp};
          void'(sample_q.pop_front());
          s_axis_tvalid <= 1'b1;
          src_gap <= rand_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    comp_t e;
    int unsigned bad;
    bad = 0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (comp_q.size() == 0) begin
          $error("result transaction with nothing expected: %h", m_axis_tdata);
          bad++;
        end else begin
          e = comp_q.pop_front();
          if (m_axis_tdata[31:0] !== e.temp_centi) begin
            $error("temperature_centi exp %0d got %0d", $signed(e.temp_centi),
                   $signed(m_axis_tdata[31:0]));
            bad++;
          end
          if (m_axis_tdata[63:32] !== e.press_q24_8) begin
            $error("pressure_q24_8 exp %h got %h", e.press_q24_8, m_axis_tdata[63:32]);
            bad++;
          end
          if (m_axis_tuser[0] !== e.press_valid) begin
            $error("pressure_valid exp %0b got %0b", e.press_valid, m_axis_tuser[0]);
            bad++;
          end
        end
      end
      if (bad > 0) err_cnt <= err_cnt + bad;
      if (sink_stall > 0) begin
        sink_stall <= sink_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready) sink_stall <= rand_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_calib(input logic [btpc_pkg::CfgIdxW-1:0] idx,
                             input logic [btpc_pkg::CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    if (idx <= btpc_pkg::CFG_P8_P9) calib[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_q.size() > 0 || s_axis_tvalid || comp_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] jitter(input logic [15:0] v);
    return v + 16'($urandom_range(0, 255)) - 16'd128;
  endfunction

  initial begin
    logic [btpc_pkg::CfgW-1:0] w [6];
    sample_t s;
    foreach (calib[i]) calib[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: foreach (w[i]) w[i] = '0;
        1: begin
          w = '{32'h674B_6B70, 32'h8E7D_FC18, 32'h0BD0_D643, 32'h008C_0B27,
                32'h3C8C_FFF9, 32'h1770_C6F8};
        end
        2: foreach (w[i]) w[i] = 32'hFFFF_FFFF;
        3: begin
          w = '{32'h674B_6B70, 32'h0000_FC18, 32'h0BD0_D643, 32'h008C_0B27,
                32'h3C8C_FFF9, 32'h1770_C6F8};
        end
        4: foreach (w[i]) w[i] = 32'h8000_7FFF;
        5: foreach (w[i]) w[i] = 32'h7FFF_8000;
        default: begin
          if (ph % 2 == 0) begin
            foreach (w[i]) w[i] = $urandom();
          end else begin
            w[0] = {jitter(16'h674B), jitter(16'h6B70)};
            w[1] = {jitter(16'h8E7D), jitter(16'hFC18)};
            w[2] = {jitter(16'h0BD0), jitter(16'hD643)};
            w[3] = {jitter(16'h008C), jitter(16'h0B27)};
            w[4] = {jitter(16'h3C8C), jitter(16'hFFF9)};
            w[5] = {jitter(16'h1770), jitter(16'hC6F8)};
          end
        end
      endcase
      if (ph > 0) begin
        for (int i = 0; i < 6; i++) write_calib(btpc_pkg::CfgIdxW'(i), w[i]);
        write_calib(CfgUnused, $urandom());
      end

      // field extremes
      if (ph < 2) begin
        sample_q.push_back('{adc_temp: '0, adc_press: '0});
        sample_q.push_back('{adc_temp: '1, adc_press: '1});
        sample_q.push_back('{adc_temp: '0, adc_press: '1});
        sample_q.push_back('{adc_temp: '1, adc_press: '0});
        sample_q.push_back('{adc_temp: 20'h80000, adc_press: 20'h80000});
        sample_q.push_back('{adc_temp: 20'h7FFFF, adc_press: 20'h7FFFF});
        sample_q.push_back('{adc_temp: 20'd519888, adc_press: 20'd415148});
      end

      for (int k = 0; k < ItemsPerPhase; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          s.adc_temp = 20'($urandom());
          s.adc_press = 20'($urandom());
        end else begin
          s.adc_temp = 20'($urandom_range(400000, 620000));
          s.adc_press = 20'($urandom_range(250000, 500000));
        end
        sample_q.push_back(s);
      end
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
